// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mdsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdsa_pkg;

  localparam int MAX_ROUTES = 8;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_W      = 16;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = DEB_W'(35);
  localparam logic [COUNT_W-1:0] MAX_ROUTES_C   = COUNT_W'(MAX_ROUTES);

  typedef enum logic [1:0] {
    REG_ROUTE_COUNT      = 2'd0,
    REG_ACTIVE_HIGH_MASK = 2'd1,
    REG_INVERT_MASK      = 2'd2,
    REG_DEBOUNCE_MS      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic idle_level;
    logic level;
    logic active_high;
    logic invert;
  } route_ctl_t;

  typedef struct packed {
    logic pressed;
    logic stable_next;
  } route_stat_t;

endpackage

`default_nettype wire

// File: rtl/mdsa_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mdsa_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  raw_levels;

  modport source (output valid, output now_ms, output raw_levels, input ready);
  modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

`default_nettype wire

// File: rtl/mdsa_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mdsa_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pressed_mask;
  logic [3:0] pressed_count;
  logic       any_pressed;
  logic       first_stable_level;
  logic       press_edge;
  logic       release_edge;

  modport source (
    output valid, output pressed_mask, output pressed_count, output any_pressed,
    output first_stable_level, output press_edge, output release_edge,
    input ready
  );
  modport sink (
    input valid, input pressed_mask, input pressed_count, input any_pressed,
    input first_stable_level, input press_edge, input release_edge,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/mdsa_route.sv
`timescale 1ns / 1ps
`default_nettype none

module mdsa_route (
  input  logic                                clk,
  input  logic                                rst,
  input  mdsa_pkg::route_ctl_t                ctl,
  input  logic [mdsa_pkg::TIME_W-1:0]         now_ms,
  input  logic [mdsa_pkg::DEB_W-1:0]          debounce_ms,
  output mdsa_pkg::route_stat_t               stat
);
  import mdsa_pkg::*;

  logic              seen;
  logic              stable;
  logic              observed;
  logic [TIME_W-1:0] change_time;

  logic              obs_cur;
  logic              st_cur;
  logic [TIME_W-1:0] ct_cur;
  logic              observed_next;
  logic [TIME_W-1:0] change_time_next;
  logic              stable_next;
  logic [TIME_W-1:0] elapsed;

  always_comb begin
    obs_cur = seen ? observed : ctl.level;
    st_cur  = seen ? stable : ctl.level;
    ct_cur  = seen ? change_time : now_ms;
    if (ctl.level != obs_cur) begin
      observed_next    = ctl.level;
      change_time_next = now_ms;
    end else begin
      observed_next    = obs_cur;
      change_time_next = ct_cur;
    end
    elapsed     = now_ms - change_time_next;
    stable_next = (elapsed >= TIME_W'(debounce_ms)) ? observed_next : st_cur;
  end

  assign stat.stable_next = stable_next;
  assign stat.pressed     = (stable_next == ctl.active_high) ^ ctl.invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (ctl.restart) begin
      seen <= 1'b0;
    end else if (ctl.step) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.restart) begin
      stable   <= ctl.idle_level;
      observed <= ctl.idle_level;
    end else if (ctl.step) begin
      stable      <= stable_next;
      observed    <= observed_next;
      change_time <= change_time_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_switch_debounce_aggregator.sv
// Debounces up to eight switch routes and reports an aggregate pressed state.
// Channels: sample (sink) carries now_ms and raw_levels; result (source)
// carries pressed_mask, pressed_count, any_pressed, first_stable_level and
// the press/release edges of any_pressed. Each sample word yields exactly
// one result word.
// Configuration: cfg_we, cfg_index, cfg_data write route_count,
// active_high_mask, invert_mask or debounce_ms; writing any of the first
// three restarts all routes. Write only while no word is in flight.
// Result is valid in the cycle after sample accept. Throughput: one word per
// cycle while result.ready is high, set by the single combinational pass of
// eight parallel 32-bit elapsed-time compares into the result register.
// Stall: while the result register holds an untaken word, sample.ready
// follows result.ready, so a new word is taken in the same cycle the old
// one leaves.
// Reset: registers take their reset values (debounce 35 ms, no routes),
// all routes unseen, result empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multi_switch_debounce_aggregator (
  input  logic                          clk,
  input  logic                          rst,
  mdsa_sample_if.sink                   sample,
  mdsa_result_if.source                 result,
  input  logic                          cfg_we,
  input  mdsa_pkg::reg_index_t          cfg_index,
  input  logic [mdsa_pkg::CFG_W-1:0]    cfg_data
);
  import mdsa_pkg::*;

  logic [COUNT_W-1:0]    route_count;
  logic [MAX_ROUTES-1:0] active_high_mask;
  logic [MAX_ROUTES-1:0] invert_mask;
  logic [DEB_W-1:0]      debounce_ms;
  logic                  prev_any;

  logic                  accept;
  logic                  restart;
  logic [MAX_ROUTES-1:0] idle_levels;
  logic [COUNT_W-1:0]    n_eff;
  logic                  no_routes;
  logic [MAX_ROUTES-1:0] enabled;
  logic [MAX_ROUTES-1:0] mask_next;
  logic [COUNT_W-1:0]    count_next;
  logic                  any_next;

  route_ctl_t  ctl  [MAX_ROUTES];
  route_stat_t stat [MAX_ROUTES];

  assign accept    = sample.valid && sample.ready;
  assign sample.ready = !result.valid || result.ready;
  assign restart   = cfg_we && (cfg_index != REG_DEBOUNCE_MS);
  assign idle_levels = ~((cfg_we && cfg_index == REG_ACTIVE_HIGH_MASK) ?
                         cfg_data[MAX_ROUTES-1:0] : active_high_mask);
  assign n_eff     = (route_count > MAX_ROUTES_C) ? MAX_ROUTES_C : route_count;
  assign no_routes = (n_eff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count      <= '0;
      active_high_mask <= '0;
      invert_mask      <= '0;
      debounce_ms      <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROUTE_COUNT:      route_count      <= cfg_data[COUNT_W-1:0];
        REG_ACTIVE_HIGH_MASK: active_high_mask <= cfg_data[MAX_ROUTES-1:0];
        REG_INVERT_MASK:      invert_mask      <= cfg_data[MAX_ROUTES-1:0];
        REG_DEBOUNCE_MS:      debounce_ms      <= cfg_data[DEB_W-1:0];
      endcase
    end
  end

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_route
    assign enabled[i] = (COUNT_W'(i) < n_eff);
    assign ctl[i].step        = accept && enabled[i];
    assign ctl[i].restart     = restart;
    assign ctl[i].idle_level  = idle_levels[i];
    assign ctl[i].level       = sample.raw_levels[i];
    assign ctl[i].active_high = active_high_mask[i];
    assign ctl[i].invert      = invert_mask[i];
    assign mask_next[i]       = enabled[i] && stat[i].pressed;

    mdsa_route u_route (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[i]),
      .now_ms      (sample.now_ms),
      .debounce_ms (debounce_ms),
      .stat        (stat[i])
    );
  end

  always_comb begin
    count_next = '0;
    for (int k = 0; k < MAX_ROUTES; k++) begin
      count_next = count_next + COUNT_W'(mask_next[k]);
    end
    any_next = (mask_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      prev_any     <= 1'b0;
    end else begin
      if (accept) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (restart) begin
        prev_any <= 1'b0;
      end else if (accept) begin
        prev_any <= any_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.pressed_mask       <= mask_next;
      result.pressed_count      <= count_next;
      result.any_pressed        <= any_next;
      result.first_stable_level <= no_routes ? 1'b1 : stat[0].stable_next;
      result.press_edge         <= any_next && !prev_any;
      result.release_edge       <= !no_routes && !any_next && prev_any;
    end
  end

  `ASSERT_NEXT(a_no_routes, clk, rst, accept && no_routes,
               result.pressed_count == '0 && result.first_stable_level)
  `ASSERT_NOW(a_count_any, clk, rst, result.valid,
              (result.pressed_count == COUNT_W'($countones(result.pressed_mask))) &&
              (result.any_pressed == (result.pressed_count != '0)))
  `ASSERT_NEXT(a_prev_tracks, clk, rst, accept && !restart,
               prev_any == result.any_pressed)

endmodule

`default_nettype wire

// File: verif/tb_multi_switch_debounce_aggregator.sv
`timescale 1ns / 1ps

module tb_multi_switch_debounce_aggregator;
  import mdsa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  raw;
  } sample_word_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [3:0] count;
    logic       any;
    logic       first;
    logic       rise;
    logic       fall;
  } switch_state_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  reg_index_t           cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mdsa_sample_if sample_ch();
  mdsa_result_if result_ch();

  multi_switch_debounce_aggregator i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  route_cnt;
  logic [7:0]  hi_mask;
  logic [7:0]  inv_mask;
  logic [15:0] deb_ms;
  logic [7:0]  seen;
  logic [7:0]  stab;
  logic [7:0]  obs;
  logic [31:0] chg [8];
  logic        prev_any;

  sample_word_t  sample_queue [$];
  switch_state_t expected_results [$];
  switch_state_t want;
  sample_word_t  next_word;
  logic          word_taken = 1'b0;
  logic          calm = 1'b0;
  int            send_gap = 0;
  int            stall_gap = 0;
  int            mismatches = 0;
  int            cycles = 0;

  function automatic void clear_route_state();
    int i;
    for (i = 0; i < MAX_ROUTES; i++) begin
      seen[i] = 1'b0;
      stab[i] = ~hi_mask[i];
      obs[i]  = ~hi_mask[i];
      chg[i]  = '0;
    end
    prev_any = 1'b0;
  endfunction

  function automatic void power_on_state();
    route_cnt = '0;
    hi_mask   = '0;
    inv_mask  = '0;
    deb_ms    = DEBOUNCE_RESET;
    clear_route_state();
  endfunction

  function automatic switch_state_t debounce_sample(input logic [31:0] t,
                                                    input logic [7:0] raw);
    switch_state_t r;
    int            i;
    int            n;
    logic          lv;
    logic          base;
    r = '0;
    n = (route_cnt > 4'd8) ? MAX_ROUTES : int'(route_cnt);
    if (n == 0) begin
      prev_any = 1'b0;
      r.first = 1'b1;
      return r;
    end
    for (i = 0; i < n; i++) begin
      lv = raw[i];
      if (!seen[i]) begin
        seen[i] = 1'b1;
        stab[i] = lv;
        obs[i]  = lv;
        chg[i]  = t;
      end
      if (lv != obs[i]) begin
        obs[i] = lv;
        chg[i] = t;
      end
      if (32'(t - chg[i]) >= {16'd0, deb_ms})
        stab[i] = obs[i];
      base = (stab[i] == hi_mask[i]);
      if (base ^ inv_mask[i]) begin
        r.mask[i] = 1'b1;
        r.count = r.count + 4'd1;
      end
    end
    r.any   = (r.count != 0);
    r.first = stab[0];
    r.rise  = r.any && !prev_any;
    r.fall  = !r.any && prev_any;
    prev_any = r.any;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic program_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ROUTE_COUNT: begin
        route_cnt = data[3:0];
        clear_route_state();
      end
      REG_ACTIVE_HIGH_MASK: begin
        hi_mask = data[7:0];
        clear_route_state();
      end
      REG_INVERT_MASK: begin
        inv_mask = data[7:0];
        clear_route_state();
      end
      REG_DEBOUNCE_MS: deb_ms = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic [31:0] t, input logic [7:0] raw);
    sample_word_t w;
    w.now = t;
    w.raw = raw;
    sample_queue.insert(sample_queue.size(), w);
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || sample_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic shuffle_settings();
    logic [CFG_W-1:0] data;
    bit               wrote;
    wrote = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      data = CFG_W'($urandom);
      program_reg(REG_ACTIVE_HIGH_MASK, data);
      wrote = 1'b1;
    end
    if ($urandom_range(0, 1) == 0) begin
      data = CFG_W'($urandom);
      program_reg(REG_INVERT_MASK, data);
      wrote = 1'b1;
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       data = '0;
        1:       data = 16'hFFFF;
        2:       data = 16'd1;
        default: data = CFG_W'($urandom_range(2, 120));
      endcase
      program_reg(REG_DEBOUNCE_MS, data);
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 1) == 0) begin
      data = CFG_W'($urandom);
      case ($urandom_range(0, 9))
        0:       data[3:0] = 4'd0;
        1, 2:    data[3:0] = 4'($urandom_range(9, 15));
        default: data[3:0] = 4'($urandom_range(1, 8));
      endcase
      program_reg(REG_ROUTE_COUNT, data);
    end
  endtask

  task automatic gen_traffic(input int count);
    logic [31:0] t;
    logic [7:0]  lv;
    int          k;
    int          j;
    if ($urandom_range(0, 3) == 0)
      t = 32'hFFFF_FFFF - $urandom_range(0, 3 * deb_ms + 200);
    else
      t = $urandom;
    lv = 8'($urandom);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0:       t = $urandom;
        1:       t = t + deb_ms;
        2:       t = t + deb_ms + 1;
        3:       t = t - $urandom_range(1, 50);
        default: t = t + $urandom_range(0, deb_ms / 4 + 3);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          j = $urandom_range(0, 7);
          lv[j] = ~lv[j];
        end
        3:       lv = 8'($urandom);
        default: ;
      endcase
      push_sample(t, lv);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      if (!sample_ch.valid || word_taken) begin
        if (send_gap > 0) begin
          sample_ch.valid <= 1'b0;
          send_gap--;
        end else if (sample_queue.size() > 0) begin
          next_word = sample_queue.pop_front();
          sample_ch.valid      <= 1'b1;
          sample_ch.now_ms     <= next_word.now;
          sample_ch.raw_levels <= next_word.raw;
          if (!calm && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 4);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        result_ch.ready <= 1'b0;
        stall_gap--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0)
          stall_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    word_taken = !rst && sample_ch.valid && sample_ch.ready;
    if (word_taken)
      expected_results.insert(expected_results.size(),
                              debounce_sample(sample_ch.now_ms, sample_ch.raw_levels));
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("word with nothing expected", 32'(result_ch.pressed_mask), 0);
      end else begin
        want = expected_results.pop_front();
        if (result_ch.pressed_mask !== want.mask)
          report_mismatch("pressed_mask", 32'(result_ch.pressed_mask), 32'(want.mask));
        if (result_ch.pressed_count !== want.count)
          report_mismatch("pressed_count", 32'(result_ch.pressed_count), 32'(want.count));
        if (result_ch.any_pressed !== want.any)
          report_mismatch("any_pressed", 32'(result_ch.any_pressed), 32'(want.any));
        if (result_ch.first_stable_level !== want.first)
          report_mismatch("first_stable_level", 32'(result_ch.first_stable_level),
                          32'(want.first));
        if (result_ch.press_edge !== want.rise)
          report_mismatch("press_edge", 32'(result_ch.press_edge), 32'(want.rise));
        if (result_ch.release_edge !== want.fall)
          report_mismatch("release_edge", 32'(result_ch.release_edge), 32'(want.fall));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_ROUTE_COUNT;
    cfg_data             = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.now_ms     = '0;
    sample_ch.raw_levels = '0;
    result_ch.ready      = 1'b0;
    power_on_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no routes after reset
    push_sample(32'h0000_0000, 8'hFF);
    push_sample(32'hFFFF_FFFF, 8'h00);
    drain();

    // full width, bounce and accept across the timestamp wrap
    program_reg(REG_ROUTE_COUNT, 16'd8);
    program_reg(REG_ACTIVE_HIGH_MASK, 16'h00A5);
    program_reg(REG_INVERT_MASK, 16'h0000);
    program_reg(REG_DEBOUNCE_MS, 16'd10);
    push_sample(32'hFFFF_FFF8, 8'h00);
    push_sample(32'hFFFF_FFFC, 8'hFF);
    push_sample(32'h0000_0002, 8'hFF);
    push_sample(32'h0000_0006, 8'hFF);
    push_sample(32'h0000_0007, 8'h00);
    push_sample(32'h0000_0008, 8'hFF);
    push_sample(32'h0000_0012, 8'hFF);
    drain();

    // oversized route count, full inversion, zero debounce
    program_reg(REG_ROUTE_COUNT, 16'hABCF);
    program_reg(REG_INVERT_MASK, 16'hFFFF);
    program_reg(REG_DEBOUNCE_MS, 16'd0);
    push_sample(32'd5, 8'hFF);
    push_sample(32'd5, 8'h00);
    push_sample(32'd6, 8'h5A);
    push_sample(32'd6, 8'hFF);
    drain();

    // single route, longest debounce
    program_reg(REG_ROUTE_COUNT, 16'd1);
    program_reg(REG_ACTIVE_HIGH_MASK, 16'h0001);
    program_reg(REG_INVERT_MASK, 16'h0000);
    program_reg(REG_DEBOUNCE_MS, 16'hFFFF);
    push_sample(32'd100, 8'h01);
    push_sample(32'd200, 8'h00);
    push_sample(32'd65734, 8'h00);
    push_sample(32'd65735, 8'h00);
    drain();

    repeat (13) begin
      shuffle_settings();
      calm = ($urandom_range(0, 4) == 0);
      gen_traffic(95);
      drain();
    end

    // settle with no idling on either side
    program_reg(REG_ROUTE_COUNT, 16'd8);
    program_reg(REG_ACTIVE_HIGH_MASK, 16'h00FF);
    program_reg(REG_INVERT_MASK, 16'h0000);
    program_reg(REG_DEBOUNCE_MS, 16'd3);
    calm = 1'b1;
    gen_traffic(100);
    drain();

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
